/* design/bfrf_pkg.sv */
// bfrf_pkg: shared constants, types and a helper function for the bitmap free run finder
// no dependencies; used by the interfaces, the step unit and the top level
`default_nettype none

package bfrf_pkg;

   localparam int WORD_BITS       = 64;
   localparam int BITMAP_WORDS    = 1024;
   localparam int NEARBY_DISTANCE = 64;
   localparam int WORD_ADDR_W     = 10;
   localparam int USED_W          = 11;
   localparam int POS_W           = 17;
   localparam int NEED_W          = 17;
   localparam int BIT_POS_W       = 16;
   localparam int NEAR_W          = 16;
   localparam int BIT_IDX_W       = 6;

   localparam logic [USED_W-1:0] WIU_RESET = USED_W'(BITMAP_WORDS);

   // item action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_FIND  = 1'b1;

   // search phases
   typedef enum logic {
      PH_NEAR,
      PH_BELOW
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_EVAL,
      ST_ENDSPAN,
      ST_DONE
   } fsm_state_type;

   // outcome of one scan step
   typedef struct packed {
      logic                 advance;
      logic                 report;
      logic [POS_W-1:0]     start_next;
      logic [WORD_BITS-1:0] word_next;
      logic [POS_W-1:0]     run_pos;
      logic [POS_W-1:0]     run_len;
   } step_out_type;

   // index of the lowest set bit, 0 for an empty word
   function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
      logic [BIT_IDX_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            r = BIT_IDX_W'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/bfrf_if.sv */
// bfrf channel interfaces: request, response and register write channels
// depends on bfrf_pkg for field widths
`default_nettype none

interface bfrf_req_if;
   import bfrf_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   action;
   logic [WORD_ADDR_W-1:0] word_index;
   logic [WORD_BITS-1:0]   word_value;
   logic [NEED_W-1:0]      need_bits;
   logic [NEAR_W-1:0]      near_bit;
   modport source (output valid, action, word_index, word_value, need_bits, near_bit,
                   input ready);
   modport sink   (input valid, action, word_index, word_value, need_bits, near_bit,
                   output ready);
endinterface

interface bfrf_rsp_if;
   import bfrf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 was_search;
   logic                 found;
   logic [BIT_POS_W-1:0] bit_pos;
   modport source (output valid, was_search, found, bit_pos, input ready);
   modport sink   (input valid, was_search, found, bit_pos, output ready);
endinterface

interface bfrf_csr_if;
   import bfrf_pkg::*;
   logic              valid;
   logic              ready;
   logic [USED_W-1:0] words_in_use;
   modport source (output valid, words_in_use, input ready);
   modport sink   (input valid, words_in_use, output ready);
endinterface

`default_nettype wire

/* design/bitmap_free_run_finder.sv */
// bitmap_free_run_finder: bitmap store in ram, search sequencer and result register
// depends on bfrf_pkg, bfrf_if, bfrf_ram and bfrf_step
// a write, or a search with zero need or a near word outside words_in_use, passes through the done state to
// the result register. a search reads each word from ram, takes a step per set bit plus one at each word
// end (a full word one step, a run reported at the span end one more), an eval state per run reported,
// an endspan per span end, then done. a new item is taken once the previous one is in the result
// register; reset clears control state and sets words_in_use to 1024, the bitmap memory is not cleared.
`default_nettype none

module bitmap_free_run_finder (
   input  logic       clock,
   input  logic       reset,
   bfrf_req_if.sink   req,
   bfrf_rsp_if.source rsp,
   bfrf_csr_if.sink   csr
);
   import bfrf_pkg::*;

   fsm_state_type          state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [USED_W-1:0]      wiu_ff;
   logic [NEED_W-1:0]      need_ff, need_in;
   logic [WORD_ADDR_W-1:0] hw_ff, hw_in;
   logic [WORD_ADDR_W-1:0] base_ff, base_in;
   logic [WORD_ADDR_W-1:0] addr_ff, addr_in;
   logic [USED_W-1:0]      end_ff, end_in;
   logic                   have_ff, have_in;
   logic [POS_W-1:0]       bpos_ff, bpos_in;
   logic [POS_W-1:0]       blen_ff, blen_in;
   logic [POS_W-1:0]       start_ff, start_in;
   logic [WORD_BITS-1:0]   word_ff, word_in;
   logic                   fresh_ff, fresh_in;
   logic [POS_W-1:0]       run_pos_ff, run_pos_in;
   logic [POS_W-1:0]       run_len_ff, run_len_in;
   logic                   res_search_ff, res_search_in;
   logic                   res_found_ff, res_found_in;
   logic [BIT_POS_W-1:0]   res_pos_ff, res_pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_search_ff, rsp_search_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [BIT_POS_W-1:0]   rsp_pos_ff, rsp_pos_in;

   logic                   req_xfer;
   logic                   can_load;
   logic [USED_W-1:0]      used;
   logic [WORD_ADDR_W-1:0] req_hw;
   logic                   req_bad;
   logic                   last_word;
   logic [POS_W-1:0]       org;
   step_out_type           step;
   logic                   upd;
   logic [POS_W-1:0]       nbpos;
   logic [POS_W-1:0]       nblen;
   logic                   exact;
   logic                   cut;
   logic [POS_W-1:0]       pick;
   logic [POS_W-1:0]       sel_pos;
   logic [BIT_POS_W-1:0]   fin_pos;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [WORD_ADDR_W-1:0] ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_rd_data;

   // handshakes
   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign req_xfer  = req.valid && req.ready;
   assign can_load  = !rsp_valid_ff || rsp.ready;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.was_search = rsp_search_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.bit_pos    = rsp_pos_ff;

   // request decode
   always_comb begin
      used    = (wiu_ff > USED_W'(BITMAP_WORDS)) ? USED_W'(BITMAP_WORDS) : wiu_ff;
      req_hw  = req.near_bit[NEAR_W-1:BIT_IDX_W];
      req_bad = (req.need_bits == '0) || ({1'b0, req_hw} >= used);
   end

   // word position within the span
   always_comb begin
      last_word = (({1'b0, addr_ff} + USED_W'(1)) == end_ff);
      org       = {1'b0, addr_ff - base_ff, {BIT_IDX_W{1'b0}}};
   end

   bfrf_step u_step (
      .word      (word_ff),
      .fresh     (fresh_ff),
      .org       (org),
      .start     (start_ff),
      .need      (need_ff),
      .last_word (last_word),
      .res       (step)
   );

   // evaluation of a reported run: best fit in the near phase, first fit below
   always_comb begin
      upd     = !have_ff || (blen_ff > run_len_ff);
      nbpos   = upd ? run_pos_ff : bpos_ff;
      nblen   = upd ? run_len_ff : blen_ff;
      exact   = (run_len_ff == need_ff);
      cut     = (hw_ff != '0) &&
                ({1'b0, run_pos_ff} > ((POS_W+1)'(NEARBY_DISTANCE) + {1'b0, need_ff}));
      pick    = (nblen < run_len_ff) ? nbpos : run_pos_ff;
      sel_pos = (state_ff == ST_ENDSPAN) ? bpos_ff :
                ((phase_ff == PH_NEAR) && !exact) ? pick : run_pos_ff;
      fin_pos = BIT_POS_W'(sel_pos + {1'b0, base_ff, {BIT_IDX_W{1'b0}}});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if ((req.action == ACT_WRITE) || req_bad) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (step.report) begin
               state_in = ST_EVAL;
            end else if (step.advance) begin
               state_in = last_word ? ST_ENDSPAN : ST_READ;
            end
         end
         ST_EVAL: begin
            if ((phase_ff == PH_BELOW) || exact || cut) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_ENDSPAN: begin
            if ((phase_ff == PH_NEAR) && !have_ff && (hw_ff != '0)) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in      = phase_ff;
      need_in       = need_ff;
      hw_in         = hw_ff;
      base_in       = base_ff;
      addr_in       = addr_ff;
      end_in        = end_ff;
      have_in       = have_ff;
      bpos_in       = bpos_ff;
      blen_in       = blen_ff;
      start_in      = start_ff;
      word_in       = word_ff;
      fresh_in      = fresh_ff;
      run_pos_in    = run_pos_ff;
      run_len_in    = run_len_ff;
      res_search_in = res_search_ff;
      res_found_in  = res_found_ff;
      res_pos_in    = res_pos_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               res_search_in = req.action;
               res_found_in  = 1'b0;
               res_pos_in    = '0;
               need_in       = req.need_bits;
               hw_in         = req_hw;
               base_in       = req_hw;
               addr_in       = req_hw;
               end_in        = used;
               phase_in      = PH_NEAR;
               have_in       = 1'b0;
               start_in      = '0;
               if (req.action == ACT_WRITE) begin
                  ram_wr_en = 1'b1;
               end else if (!req_bad) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = req_hw;
               end
            end
         end
         ST_READ: begin
            word_in  = ram_rd_data;
            fresh_in = 1'b1;
         end
         ST_SCAN: begin
            word_in    = step.word_next;
            start_in   = step.start_next;
            fresh_in   = 1'b0;
            run_pos_in = step.run_pos;
            run_len_in = step.run_len;
            if (step.advance && !last_word) begin
               addr_in     = addr_ff + WORD_ADDR_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = addr_ff + WORD_ADDR_W'(1);
            end
         end
         ST_EVAL: begin
            have_in = 1'b1;
            bpos_in = nbpos;
            blen_in = nblen;
            if ((phase_ff == PH_BELOW) || exact || cut) begin
               res_found_in = 1'b1;
               res_pos_in   = fin_pos;
            end
         end
         ST_ENDSPAN: begin
            if ((phase_ff == PH_NEAR) && have_ff) begin
               res_found_in = 1'b1;
               res_pos_in   = fin_pos;
            end else if ((phase_ff == PH_NEAR) && (hw_ff != '0)) begin
               // first-fit pass over the words below the near word
               phase_in    = PH_BELOW;
               base_in     = '0;
               addr_in     = '0;
               end_in      = {1'b0, hw_ff};
               start_in    = '0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_search_in = rsp_search_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      if ((state_ff == ST_DONE) && can_load) begin
         rsp_valid_in  = 1'b1;
         rsp_search_in = res_search_ff;
         rsp_found_in  = res_found_ff;
         rsp_pos_in    = res_pos_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   bfrf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (BITMAP_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req.word_index),
      .wr_data (req.word_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wiu_ff       <= WIU_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            wiu_ff <= csr.words_in_use;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      need_ff       <= need_in;
      hw_ff         <= hw_in;
      base_ff       <= base_in;
      addr_ff       <= addr_in;
      end_ff        <= end_in;
      have_ff       <= have_in;
      bpos_ff       <= bpos_in;
      blen_ff       <= blen_in;
      start_ff      <= start_in;
      word_ff       <= word_in;
      fresh_ff      <= fresh_in;
      run_pos_ff    <= run_pos_in;
      run_len_ff    <= run_len_in;
      res_search_ff <= res_search_in;
      res_found_ff  <= res_found_in;
      res_pos_ff    <= res_pos_in;
      rsp_search_ff <= rsp_search_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

endmodule

`default_nettype wire

/* design/bfrf_ram.sv */
// bfrf_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module bfrf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/bfrf_step.sv */
// bfrf_step: one scan step over the working bitmap word, clearing its lowest set bit unless it is a fresh full word
// depends on bfrf_pkg
`default_nettype none

module bfrf_step (
   input  logic [bfrf_pkg::WORD_BITS-1:0] word,
   input  logic                           fresh,
   input  logic [bfrf_pkg::POS_W-1:0]     org,
   input  logic [bfrf_pkg::POS_W-1:0]     start,
   input  logic [bfrf_pkg::NEED_W-1:0]    need,
   input  logic                           last_word,
   output bfrf_pkg::step_out_type         res
);
   import bfrf_pkg::*;

   logic [BIT_IDX_W-1:0] low;
   logic [POS_W-1:0]     p_end;
   logic [POS_W-1:0]     p_bit;
   logic [POS_W-1:0]     gap_end;
   logic [POS_W-1:0]     gap_bit;

   // candidate run ends
   always_comb begin
      low     = lowest_set(word);
      p_end   = org + POS_W'(WORD_BITS);
      p_bit   = org + POS_W'(low);
      gap_end = p_end - start;
      gap_bit = p_bit - start;
   end

   // step decision
   always_comb begin
      res            = '0;
      res.start_next = start;
      res.word_next  = word;
      res.run_pos    = start;
      if (fresh && (&word)) begin
         // full word closes any open run without a report
         res.advance    = 1'b1;
         res.start_next = p_end;
      end else if (word == '0) begin
         res.run_len = gap_end;
         if ((gap_end >= need) && last_word) begin
            res.report     = 1'b1;
            res.start_next = p_end;
         end else begin
            res.advance = 1'b1;
         end
      end else begin
         res.run_len    = gap_bit;
         res.report     = (gap_bit >= need);
         res.start_next = p_bit + POS_W'(1);
         res.word_next  = word & (word - WORD_BITS'(1));
      end
   end

endmodule

`default_nettype wire

/* design/bfrf_checker.sv */
// bfrf_checker: port-level assertions for the bitmap free run finder, bound to the top
// depends on the top level bitmap_free_run_finder
`default_nettype none

module bfrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_was_search,
   input logic        rsp_found,
   input logic [15:0] rsp_bit_pos
);

   // a pending result stays until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // write acknowledge carries no position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_search |-> !rsp_found && (rsp_bit_pos == 16'd0))
      else $error("write acknowledge with search data");

   // a failed search reports position zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_bit_pos == 16'd0))
      else $error("not found with nonzero position");

   // no result right after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bitmap_free_run_finder bfrf_checker u_bfrf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_was_search (rsp.was_search),
   .rsp_found      (rsp.found),
   .rsp_bit_pos    (rsp.bit_pos)
);

`default_nettype wire
